// ----- design/tce_pkg.sv -----
// Shared types and codes of the toy CPU execute core.
package tce_pkg;

  // Opcodes
  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_ADDHI = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_BNE   = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd5;
  localparam logic [3:0] OP_ST    = 4'd6;
  localparam logic [3:0] OP_STH   = 4'd7;
  localparam logic [3:0] OP_STB   = 4'd8;
  localparam logic [3:0] OP_RTE   = 4'd9;

  // Request kinds
  localparam logic [1:0] REQ_FETCH = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_NONE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_HALTED  = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  localparam logic [31:0] IRQ_VECTOR = 32'd4;
  localparam logic [31:0] PC_STEP    = 32'd4;

  typedef struct packed {
    logic              bus_fault;
    logic              irq_pending;
    logic [3:0]        opcode;
    logic [4:0]        dest_reg;
    logic [4:0]        src1_reg;
    logic [4:0]        src2_reg;
    logic signed [15:0] immediate;
  } cmp_item_t;

  typedef struct packed {
    logic [1:0]  req_kind;
    logic [31:0] req_addr;
    logic [31:0] req_data;
    logic [3:0]  req_mask;
    logic [1:0]  status;
  } req_item_t;

  // Architectural state outside the register file
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] epc;
    logic        store_in_flight;
    logic        irq_enabled;
    logic        stopped;
  } arch_t;

  // Register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } wr_t;

endpackage

// ----- design/tce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/tce_regfile.sv -----
// Register file: three read ports from RAM copies, valid bits for reset, write bypass.
module tce_regfile #(
  parameter int REG_COUNT = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [4:0]    rd_idx1,
  input  logic [4:0]    rd_idx2,
  input  logic [4:0]    rd_idx3,
  input  tce_pkg::wr_t  wr,
  output logic [31:0]   rd_data1,
  output logic [31:0]   rd_data2,
  output logic [31:0]   rd_data3
);
  import tce_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  logic [REG_COUNT-1:0] valid;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [4:0]           ridx  [3];
  logic [AW-1:0]        raddr [3];
  logic [31:0]          ram_q [3];
  logic                 ok    [3];
  logic                 hit   [3];
  logic [31:0]          byp_data;
  logic [31:0]          rdata [3];

  assign ridx[0] = rd_idx1;
  assign ridx[1] = rd_idx2;
  assign ridx[2] = rd_idx3;

  // Writes to register 0 or past the file are dropped
  assign we    = wr.en && (wr.idx != 5'd0) && (32'(wr.idx) < REG_COUNT);
  assign waddr = AW'(wr.idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_port
    assign raddr[p] = AW'(ridx[p]);

    tce_ram #(
      .WIDTH (32),
      .DEPTH (REG_COUNT)
    ) u_ram (
      .clk     (clk),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (raddr[p]),
      .rd_data (ram_q[p])
    );

    // Read-during-write returns old RAM data, so catch the write of the same edge
    always_ff @(posedge clk) begin
      if (rd_en) begin
        ok[p]  <= (ridx[p] != 5'd0) && (32'(ridx[p]) < REG_COUNT) && valid[raddr[p]];
        hit[p] <= we && (wr.idx == ridx[p]);
      end
    end

    assign rdata[p] = hit[p] ? byp_data : (ok[p] ? ram_q[p] : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  assign rd_data1 = rdata[0];
  assign rd_data2 = rdata[1];
  assign rd_data3 = rdata[2];

endmodule

// ----- design/tce_exec.sv -----
// Execute logic: decode, ALU, branch target, store lanes, interrupt entry.
module tce_exec (
  input  tce_pkg::cmp_item_t item,
  input  tce_pkg::arch_t     arch,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic [31:0]        dval,
  output tce_pkg::arch_t     arch_next,
  output tce_pkg::wr_t       wr,
  output tce_pkg::req_item_t res
);
  import tce_pkg::*;

  logic [31:0] imm32;
  logic [31:0] b_sel;
  logic [31:0] i_sel;
  logic [31:0] sum;
  logic [31:0] diff;
  logic [31:0] pc4;
  logic [31:0] br_tgt;
  logic [31:0] pc_new;
  logic        en_new;
  logic        storing;
  logic        stop;

  assign imm32  = {{16{item.immediate[15]}}, item.immediate};
  assign pc4    = arch.pc + PC_STEP;
  assign br_tgt = pc4 + b + imm32;
  assign diff   = a - (b + imm32);

  // Scaled index and immediate feed one three-input adder
  always_comb begin
    b_sel = b;
    i_sel = imm32;
    case (item.opcode)
      OP_ADDHI: i_sel = {imm32[15:0], 16'd0};
      OP_ST:    b_sel = {b[29:0], 2'b00};
      OP_STH:   b_sel = {b[30:0], 1'b0};
      default:  ;
    endcase
  end

  assign sum = a + b_sel + i_sel;

  always_comb begin
    arch_next = arch;
    wr        = '{en: 1'b0, idx: item.dest_reg, data: sum};
    res       = '{req_kind: REQ_NONE, req_addr: 32'd0, req_data: 32'd0,
                  req_mask: 4'd0, status: ST_HALTED};
    pc_new    = arch.pc;
    en_new    = arch.irq_enabled;
    storing   = 1'b0;
    stop      = 1'b0;

    if (arch.stopped) begin
      // stays halted until reset
    end else if (item.bus_fault) begin
      arch_next.stopped = 1'b1;
      res.status        = ST_FAULT;
    end else begin
      if (arch.store_in_flight) begin
        arch_next.store_in_flight = 1'b0;
      end else begin
        pc_new = pc4;
        case (item.opcode)
          OP_HALT: begin
            stop       = 1'b1;
            res.status = ST_HALTED;
          end
          OP_ADD, OP_ADDHI: wr.en = 1'b1;
          OP_SUB: begin
            wr.en   = 1'b1;
            wr.data = diff;
          end
          OP_BNE: if (a != 32'd0) pc_new = br_tgt;
          OP_BEQ: if (a == 32'd0) pc_new = br_tgt;
          OP_ST: begin
            storing      = 1'b1;
            res.req_mask = 4'hF;
          end
          OP_STH: begin
            storing      = 1'b1;
            res.req_mask = sum[1] ? 4'hC : 4'h3;
          end
          OP_STB: begin
            storing      = 1'b1;
            res.req_mask = 4'b0001 << sum[1:0];
          end
          OP_RTE: begin
            pc_new = arch.epc;
            en_new = 1'b1;
          end
          default: begin
            stop       = 1'b1;
            res.status = ST_ILLEGAL;
          end
        endcase
      end

      if (stop) begin
        arch_next.stopped = 1'b1;
        res.req_mask      = 4'd0;
      end else begin
        arch_next.irq_enabled = en_new;
        arch_next.pc          = pc_new;
        if (item.irq_pending && en_new) begin
          arch_next.epc         = pc_new;
          arch_next.pc          = IRQ_VECTOR;
          arch_next.irq_enabled = 1'b0;
        end
        res.status = ST_RUNNING;
        if (storing) begin
          arch_next.store_in_flight = 1'b1;
          res.req_kind = REQ_STORE;
          res.req_addr = sum;
          res.req_data = dval;
        end else begin
          res.req_kind = REQ_FETCH;
          res.req_addr = arch_next.pc;
        end
      end
    end
  end

endmodule

// ----- design/toy_cpu_execute_core.sv -----
// Top level of the toy CPU execute core: pipeline registers and architectural state.
//
// Usage
//   cmp channel (cmp_valid/cmp_ready/cmp): one transfer per completed bus access,
//     carrying the fault flag, the interrupt line and the fetched instruction.
//   req channel (req_valid/req_ready/req): one transfer per completion, giving the
//     next bus request (fetch, store write or none) and the core status.
//   Path: a completion taken goes through the register-file read and execute
//     register, then the result register, which shows its request.
//   Throughput: one transfer per cycle while req is accepted; the register file
//     is three 1R1W RAM copies with a write bypass, so a completion may follow
//     its predecessor in the next cycle.
//   Reset: pc 0, saved pc 0, interrupts enabled, not halted; register file
//     reads zero through per-entry valid bits cleared at once, so no clearing
//     pass is needed. The environment issues the first fetch at address 0.
//   Stall: while req is held off the result register keeps its transfer and
//     the execute stage can still hold one more; cmp_ready drops only when both
//     are full.
//   After halt, illegal opcode or bus fault every result is "no request,
//     halted" until reset.
module toy_cpu_execute_core #(
  parameter int REG_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmp_valid,
  output logic               cmp_ready,
  input  tce_pkg::cmp_item_t cmp,
  output logic               req_valid,
  input  logic               req_ready,
  output tce_pkg::req_item_t req
);
  import tce_pkg::*;

  logic      ex_valid;
  cmp_item_t ex_item;
  logic      ex_advance;
  logic      accept;
  arch_t     arch;
  arch_t     arch_next;
  wr_t       wr;
  wr_t       wr_gated;
  req_item_t res;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] rf_d;

  // Execute stage moves on when the result register is free or being emptied
  assign ex_advance = ex_valid && (!req_valid || req_ready);
  assign cmp_ready  = !ex_valid || ex_advance;
  assign accept     = cmp_valid && cmp_ready;

  // Register-file writes commit only as the instruction leaves execute
  always_comb begin
    wr_gated    = wr;
    wr_gated.en = wr.en && ex_advance;
  end

  // Read addresses come straight off the channel; data lands with ex_item
  tce_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_idx1  (cmp.src1_reg),
    .rd_idx2  (cmp.src2_reg),
    .rd_idx3  (cmp.dest_reg),
    .wr       (wr_gated),
    .rd_data1 (rf_a),
    .rd_data2 (rf_b),
    .rd_data3 (rf_d)
  );

  tce_exec u_exec (
    .item      (ex_item),
    .arch      (arch),
    .a         (rf_a),
    .b         (rf_b),
    .dval      (rf_d),
    .arch_next (arch_next),
    .wr        (wr),
    .res       (res)
  );

  // Execute stage input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (cmp_ready) begin
      ex_valid <= cmp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= cmp;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '{pc: 32'd0, epc: 32'd0, store_in_flight: 1'b0,
                irq_enabled: 1'b1, stopped: 1'b0};
    end else if (ex_advance) begin
      arch <= arch_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (ex_advance) begin
      req_valid <= 1'b1;
    end else if (req_ready) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_advance) begin
      req <= res;
    end
  end

`ifndef SYNTHESIS
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    ex_advance && arch.stopped |=> req.req_kind == REQ_NONE && req.status == ST_HALTED)
    else $error("result issued after stop");

  a_store_tracked: assert property (@(posedge clk) disable iff (rst)
    ex_advance && res.req_kind == REQ_STORE |=> arch.store_in_flight)
    else $error("store request without in-flight mark");

  a_fetch_is_pc: assert property (@(posedge clk) disable iff (rst)
    ex_advance && res.req_kind == REQ_FETCH |=> req.req_addr == arch.pc)
    else $error("fetch address differs from pc");

  a_irq_entry: assert property (@(posedge clk) disable iff (rst)
    ex_advance && !arch.stopped && !ex_item.bus_fault && ex_item.irq_pending &&
    arch.irq_enabled && res.status == ST_RUNNING
    |=> !arch.irq_enabled && arch.pc == IRQ_VECTOR)
    else $error("interrupt entry not taken");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ex_valid && req_valid && !req_ready |-> !cmp_ready)
    else $error("transfer taken with pipeline full");
`endif

endmodule
